// ===== hw/rtl/s2f_pkg.sv =====
package s2f_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxRowTaps = 8;
  localparam int MaxColTaps = 8;
  localparam int Lines      = MaxColTaps - 1;
  localparam int LineMod    = (Lines > 0) ? Lines : 1;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int SlotW      = (LineMod > 1) ? $clog2(LineMod) : 1;
  localparam int RowW       = 12;

  localparam logic [2:0] REG_ROW_LO   = 3'd0;
  localparam logic [2:0] REG_ROW_HI   = 3'd1;
  localparam logic [2:0] REG_COL_LO   = 3'd2;
  localparam logic [2:0] REG_COL_HI   = 3'd3;
  localparam logic [2:0] REG_ROW_TAPS = 3'd4;
  localparam logic [2:0] REG_COL_TAPS = 3'd5;
  localparam logic [2:0] REG_WIDTH    = 3'd6;
  localparam logic [2:0] REG_ADD_MODE = 3'd7;

  typedef struct packed {
    logic signed [31:0] sample;
    logic signed [31:0] prior_value;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] filtered_value;
    logic [11:0]        out_row;
    logic [9:0]         out_col;
  } out_item_t;

  typedef struct packed {
    logic [127:0] row_coeffs;
    logic [127:0] col_coeffs;
    logic [3:0]   row_taps;
    logic [3:0]   col_taps;
    logic [10:0]  width;
    logic         add_mode;
  } cfg_t;

  function automatic logic [3:0] clamp_taps(input logic [3:0] r, input int maxp);
    logic [3:0] t;
    t = r;
    if (t == 4'd0) t = 4'd1;
    if (t > 4'd8) t = 4'd8;
    if (int'(t) > maxp) t = 4'(maxp);
    return t;
  endfunction

  function automatic logic signed [15:0] tap_of(input logic [127:0] c, input logic [2:0] i);
    return c[{i, 4'b0000} +: 16];
  endfunction

  // round Q.30 to Q16.16: floor((v + 2^13) / 2^14)
  function automatic logic signed [51:0] round_q30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd8192;
    return 52'(t >>> 14);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    if (v > 53'sd2147483647) return 32'sh7fffffff;
    if (v < -53'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/s2f_cfg.sv =====
module s2f_cfg (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  output s2f_pkg::cfg_t   cfg
);
  import s2f_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_coeffs <= '0;
      cfg.col_coeffs <= '0;
      cfg.row_taps   <= 4'd1;
      cfg.col_taps   <= 4'd1;
      cfg.width      <= 11'd1024;
      cfg.add_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_LO:   cfg.row_coeffs[63:0]   <= cfg_data;
        REG_ROW_HI:   cfg.row_coeffs[127:64] <= cfg_data;
        REG_COL_LO:   cfg.col_coeffs[63:0]   <= cfg_data;
        REG_COL_HI:   cfg.col_coeffs[127:64] <= cfg_data;
        REG_ROW_TAPS: cfg.row_taps <= cfg_data[3:0];
        REG_COL_TAPS: cfg.col_taps <= cfg_data[3:0];
        REG_WIDTH:    cfg.width    <= cfg_data[10:0];
        REG_ADD_MODE: cfg.add_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/s2f_line_mem.sv =====
module s2f_line_mem (
  input  logic        clk,
  input  logic        we,
  input  logic [12:0] waddr,
  input  logic [31:0] wdata,
  input  logic        re,
  input  logic [12:0] raddr,
  output logic [31:0] rdata
);
  import s2f_pkg::*;

  localparam int Depth = LineMod * MaxWidth;
  logic [31:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/separable_2d_filter_valid.sv =====
// Flow: a request is accepted in S_IDLE and passes S_HOR, S_FIN, S_VER when a
// pixel is due, and S_OUT; horizontal taps run all MaxRowTaps steps, one per cycle.
// in_stall holds off a new request until the last one is back in S_IDLE;
// the vertical pass reads the line memory one tap per cycle. Output stalls hold S_OUT.
// Reset: synchronous, active high; clears config, counters, row window.
// Line memory is not cleared; within a frame at fixed width and row taps it is written before it is read.
module separable_2d_filter_valid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  s2f_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output s2f_pkg::out_item_t    out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [63:0]           cfg_data
);
  import s2f_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HOR  = 5'b00010,
    S_VER  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  cfg_t cfg;
  s2f_cfg u_cfg (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg);

  state_t state;
  in_item_t item;
  logic signed [31:0] row_window [MaxRowTaps];
  logic [ColW-1:0]  column_count;
  logic [RowW-1:0]  row_count;
  logic [SlotW-1:0] line_slot;
  logic             rows_wrapped;
  logic [3:0]       rt, ct;
  logic [3:0]       k;            // tap step counter
  logic signed [65:0] acc;
  logic signed [31:0] hval;
  logic [ColW-1:0]  hc;
  logic             emit;
  logic             hdue;         // column has a horizontal result
  logic [10:0]      w;
  logic [SlotW-1:0] rd_slot;
  logic             mem_re, mem_we, rd_pending;
  logic [12:0]      mem_raddr, mem_waddr;
  logic [31:0]      mem_rdata;
  logic [3:0]       rd_tap;
  logic signed [47:0] prod;

  s2f_line_mem u_mem (.clk, .we(mem_we), .waddr(mem_waddr), .wdata(hval),
                      .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata));

  assign in_stall = (state != S_IDLE);
  assign rt = clamp_taps(cfg.row_taps, MaxRowTaps);
  assign ct = clamp_taps(cfg.col_taps, MaxColTaps);
  assign hdue = (11'(column_count) + 11'd1 >= 11'(rt));
  always_comb begin
    w = cfg.width;
    if (w == 11'd0) w = 11'd1;
    if (w > 11'(MaxWidth)) w = 11'(MaxWidth);
  end

  // vertical read: tap k reads slot (line_slot - 1 - k) mod LineMod
  always_comb begin
    logic [4:0] s;
    s = 5'(line_slot) + 5'(LineMod) - 5'd1 - 5'(k);
    if (s >= 5'(LineMod)) s = s - 5'(LineMod);
    rd_slot = s[SlotW-1:0];
  end
  assign mem_re    = (state == S_VER) && (k + 4'd1 < ct);
  assign mem_raddr = 13'(rd_slot) * 13'(MaxWidth) + 13'(hc);
  assign mem_waddr = 13'(line_slot) * 13'(MaxWidth) + 13'(hc);
  // line write at the result stage, once hval is registered
  assign mem_we    = (state == S_OUT) && hdue && (Lines > 0);

  // one multiply per cycle feeding the accumulator
  always_comb begin
    prod = '0;
    if (state == S_HOR) begin
      if (k == 4'd0)
        prod = item.sample * tap_of(cfg.row_coeffs, 3'(rt - 4'd1));
      else if (k < rt)
        prod = row_window[3'(k - 4'd1)] * tap_of(cfg.row_coeffs, 3'(rt - 4'd1 - k));
    end else if (state == S_VER) begin
      if (rd_pending)
        prod = $signed(mem_rdata) * tap_of(cfg.col_coeffs, 3'(rd_tap));
      else if (k == 4'd0)
        prod = hval * tap_of(cfg.col_coeffs, 3'(ct - 4'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= '0;
      row_count    <= '0;
      line_slot    <= '0;
      rows_wrapped <= 1'b0;
      out_valid    <= 1'b0;
      rd_pending   <= 1'b0;
      for (int i = 0; i < MaxRowTaps; i++) row_window[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            if (in_data.frame_start) begin
              column_count <= '0; row_count <= '0;
              line_slot <= '0; rows_wrapped <= 1'b0;
              hc <= ColW'(0 - (rt - 4'd1));
            end else begin
              hc <= column_count - ColW'(rt - 4'd1);
            end
            acc <= '0;
            k   <= '0;
            state <= S_HOR;
          end
        end
        S_HOR: begin
          acc <= acc + 66'(prod);
          k   <= k + 4'd1;
          if (k == 4'(MaxRowTaps - 1)) begin
            state <= S_FIN;
          end
        end
        S_VER: begin
          // first cycle takes the newest line, then consume previous read
          if (rd_pending || k == 4'd0) acc <= acc + 66'(prod);
          rd_pending <= mem_re;
          rd_tap     <= 4'(ct - 4'd2 - k);
          k <= k + 4'd1;
          if (!mem_re && !rd_pending) begin
            state <= S_OUT;
          end
        end
        S_FIN: begin
          // horizontal result ready: decide emit, start vertical when a pixel is due
          if (hdue) begin
            hval <= sat32(53'(round_q30(acc)));
          end
          if (hdue && ((13'(row_count) + 13'd1 >= 13'(ct)) || rows_wrapped)) begin
            acc <= '0;
            k <= '0;
            rd_pending <= 1'b0;
            emit <= 1'b1;
            state <= S_VER;
          end else begin
            emit <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= emit;
            out_data.filtered_value <= sat32(53'(round_q30(acc)) +
                (cfg.add_mode ? 53'(item.prior_value) : 53'sd0));
            out_data.out_row <= row_count - 12'(ct - 4'd1);
            out_data.out_col <= 10'(hc);
            for (int i = MaxRowTaps - 1; i >= 1; i--) row_window[i] <= row_window[i-1];
            row_window[0] <= item.sample;
            if (11'(column_count) + 11'd1 >= w) begin
              column_count <= '0;
              row_count <= row_count + 12'd1;
              if (row_count == 12'hfff) rows_wrapped <= 1'b1;
              line_slot <= (32'(line_slot) + 1 >= LineMod) ? '0 : line_slot + SlotW'(1);
            end else begin
              column_count <= column_count + ColW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && !(state == S_OUT)) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_ver_after_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_VER) |-> $past(state == S_FIN)) else $error("bad vertical entry");
`endif
endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import s2f_pkg::*;

  localparam int StallLimit = 3000; // cycles without any handshake or write
  localparam int DrainWait  = 30;   // margin for the block to finish after the owed pixels are drained
  localparam int StoreLines = 7;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  separable_2d_filter_valid i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // free-running 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the filter: register file plus pipeline state.
  // ---------------------------------------------------------------------
  logic [127:0]       sh_row_coeffs;
  logic [127:0]       sh_col_coeffs;
  logic [3:0]         sh_row_taps;
  logic [3:0]         sh_col_taps;
  logic [10:0]        sh_width;
  logic               sh_add_mode;

  logic signed [31:0] win_hist [MaxRowTaps];
  logic signed [31:0] line_mem [StoreLines*MaxWidth];
  int unsigned        col_pos;
  int unsigned        row_pos;
  int unsigned        slot_pos;
  bit                 rows_wrapped;

  out_item_t          pixel_q [$];   // filtered pixels still owed by the block
  int                 mismatches;
  int                 tx_pct;        // sender idle chance, percent
  int                 rx_pct;        // receiver stall chance, percent
  bit                 force_frame;   // next request must open a new frame

  function automatic int eff_taps(logic [3:0] r);
    int t;
    t = r;
    if (t < 1) t = 1;
    if (t > 8) t = 8;
    return t;
  endfunction

  function automatic int eff_width(logic [10:0] r);
    int w;
    w = r;
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic longint coeff(logic [127:0] c, int i);
    logic signed [15:0] h;
    h = c[i*16 +: 16];
    return longint'(h);
  endfunction

  // Q.30 -> Q16.16, round half up (arithmetic shift is a floor)
  function automatic longint rnd14(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Advance the shadow filter by one request; returns 1 when a pixel is due.
  function automatic bit filter_step(in_item_t it, output out_item_t px);
    int unsigned w, rt, ct, c, hc, s;
    longint acc, hval, vacc, res;
    bit due;
    due = 1'b0;
    px  = '0;
    if (it.frame_start) begin
      col_pos = 0; row_pos = 0; slot_pos = 0; rows_wrapped = 1'b0;
    end
    w  = eff_width(sh_width);
    rt = eff_taps(sh_row_taps);
    ct = eff_taps(sh_col_taps);
    c  = col_pos;
    if (c + 1 >= rt && c < MaxWidth) begin
      hc  = c - (rt - 1);
      acc = longint'(it.sample) * coeff(sh_row_coeffs, rt - 1);
      for (int k = 0; k + 1 < rt; k++)
        acc += longint'(win_hist[k]) * coeff(sh_row_coeffs, rt - 2 - k);
      hval = clip32(rnd14(acc));
      if (row_pos + 1 >= ct || rows_wrapped) begin
        vacc = hval * coeff(sh_col_coeffs, ct - 1);
        for (int k = 0; k + 1 < ct; k++) begin
          s = (slot_pos + StoreLines - 1 - k) % StoreLines;
          vacc += longint'(line_mem[s*MaxWidth + hc]) * coeff(sh_col_coeffs, ct - 2 - k);
        end
        res = rnd14(vacc);
        if (sh_add_mode) res += longint'(it.prior_value);
        res = clip32(res);
        px.filtered_value = res[31:0];
        px.out_row        = 12'(row_pos - (ct - 1));
        px.out_col        = 10'(hc);
        due = 1'b1;
      end
      line_mem[slot_pos*MaxWidth + hc] = hval[31:0];
    end
    for (int k = MaxRowTaps - 1; k >= 1; k--)
      win_hist[k] = win_hist[k-1];
    win_hist[0] = it.sample;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 12'hfff;
      if (row_pos == 0) rows_wrapped = 1'b1;
      slot_pos = (slot_pos + 1) % StoreLines;
    end else begin
      col_pos = c + 1;
    end
    return due;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers. The main process always sits just after a falling edge.
  // ---------------------------------------------------------------------

  // One request; a typed pixel, when given, replaces the shadow's answer.
  task automatic send_request(in_item_t it, bit typed, out_item_t typed_px);
    out_item_t px;
    bit done;
    if (force_frame) it.frame_start = 1'b1;
    force_frame = 1'b0;
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      if (!in_stall) begin
        done = 1'b1;
        if (filter_step(it, px)) pixel_q.push_back(typed ? typed_px : px);
      end
      @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Drain, then rewrite the whole register file. A new frame is forced when
  // older lines could lack columns that the new setting reads.
  task automatic load_setting(logic [63:0] rlo, logic [63:0] rhi, logic [63:0] clo,
                              logic [63:0] chi, logic [3:0] rt, logic [3:0] ct,
                              logic [10:0] w, logic am);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
    if (eff_width(w) > eff_width(sh_width) || eff_taps(rt) < eff_taps(sh_row_taps))
      force_frame = 1'b1;
    write_reg(REG_ROW_LO, rlo);
    write_reg(REG_ROW_HI, rhi);
    write_reg(REG_COL_LO, clo);
    write_reg(REG_COL_HI, chi);
    write_reg(REG_ROW_TAPS, 64'(rt));
    write_reg(REG_COL_TAPS, 64'(ct));
    write_reg(REG_WIDTH, 64'(w));
    write_reg(REG_ADD_MODE, 64'(am));
    cfg_we <= 1'b0;
    sh_row_coeffs = {rhi, rlo};
    sh_col_coeffs = {chi, clo};
    sh_row_taps   = rt;
    sh_col_taps   = ct;
    sh_width      = w;
    sh_add_mode   = am;
  endtask

  // random pixel, weighted toward small values and the rails
  function automatic in_item_t rand_request();
    in_item_t it;
    case ($urandom_range(3))
      1: it.sample = $signed($urandom_range(1 << 20)) - (1 << 19);
      2: it.sample = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: it.sample = $urandom;
    endcase
    it.prior_value = $urandom;
    it.frame_start = ($urandom_range(199) == 0);
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table: setting group, request, and a typed pixel where obvious.
  // ---------------------------------------------------------------------
  typedef struct {
    int          grp;
    logic [31:0] smp;
    logic [31:0] pri;
    bit          fs;
    bit          typed;
    logic [31:0] val;
    int          row;
    int          col;
  } dir_row_t;

  localparam int DirRows = 27;
  dir_row_t dir_tab [DirRows] = '{
    // reset setting: all taps zero, one by one, replace
    '{0, 32'h0000_0005, 32'h3, 1, 1, 32'h0, 0, 0},
    '{0, 32'hffff_ffff, 32'h0, 0, 1, 32'h0, 0, 1},
    '{0, 32'h7fff_ffff, 32'h0, 0, 1, 32'h0, 0, 2},
    // unit taps, two-wide lines: pixel passes straight through
    '{1, 32'h7fff_ffff, 32'h0, 1, 1, 32'h7fff_ffff, 0, 0},
    '{1, 32'h8000_0000, 32'h0, 0, 1, 32'h8000_0000, 0, 1},
    '{1, 32'h0000_0001, 32'h0, 0, 1, 32'h0000_0001, 1, 0},
    '{1, 32'hffff_ffff, 32'h0, 0, 1, 32'hffff_ffff, 1, 1},
    // unit taps in add mode: saturation after the add
    '{2, 32'h7fff_ffff, 32'h1, 1, 1, 32'h7fff_ffff, 0, 0},
    '{2, 32'h8000_0000, 32'h8000_0000, 0, 1, 32'h8000_0000, 0, 1},
    '{2, 32'h0000_0005, 32'h3, 0, 1, 32'h0000_0008, 1, 0},
    // oversized tap count and width, rail taps
    '{3, 32'h7fff_ffff, 32'h0, 1, 0, 0, 0, 0},
    '{3, 32'h8000_0000, 32'h0, 0, 0, 0, 0, 0},
    '{3, 32'h7fff_ffff, 32'h0, 0, 0, 0, 0, 0},
    '{3, 32'h8000_0000, 32'h0, 0, 0, 0, 0, 0},
    '{3, 32'h7fff_ffff, 32'h0, 0, 0, 0, 0, 0},
    '{3, 32'h8000_0000, 32'h0, 0, 0, 0, 0, 0},
    '{3, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0},
    '{3, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0},
    // zero tap count and zero width, eight-line column
    '{4, 32'h7fff_ffff, 32'h0, 1, 0, 0, 0, 0},
    '{4, 32'h7fff_ffff, 32'h0, 0, 0, 0, 0, 0},
    '{4, 32'h7fff_ffff, 32'h0, 0, 0, 0, 0, 0},
    '{4, 32'h7fff_ffff, 32'h0, 0, 0, 0, 0, 0},
    '{4, 32'h8000_0000, 32'h0, 0, 0, 0, 0, 0},
    '{4, 32'h8000_0000, 32'h0, 0, 0, 0, 0, 0},
    '{4, 32'h8000_0000, 32'h0, 0, 0, 0, 0, 0},
    '{4, 32'h7fff_ffff, 32'h1234_5678, 0, 0, 0, 0, 0},
    '{4, 32'h8000_0000, 32'h8765_4321, 0, 0, 0, 0, 0}
  };

  task automatic load_group(int grp);
    case (grp)
      1: load_setting(64'h4000, 0, 64'h4000, 0, 4'd1, 4'd1, 11'd2, 1'b0);
      2: load_setting(64'h4000, 0, 64'h4000, 0, 4'd1, 4'd1, 11'd2, 1'b1);
      3: load_setting({4{16'h8000}}, {4{16'h8000}}, {4{16'h7fff}}, {4{16'h7fff}},
                      4'd15, 4'd0, 11'd2047, 1'b1);
      4: load_setting({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h8000}},
                      4'd0, 4'd8, 11'd0, 1'b0);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Result checker: in-order compare against the oldest owed pixel.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected pixel val=%h row=%0d col=%0d",
                   out_data.filtered_value, out_data.out_row, out_data.out_col);
      end else begin
        want = pixel_q.pop_front();
        if (out_data.filtered_value !== want.filtered_value ||
            out_data.out_row !== want.out_row || out_data.out_col !== want.out_col) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: pixel exp val=%h row=%0d col=%0d got val=%h row=%0d col=%0d",
                     want.filtered_value, want.out_row, want.out_col,
                     out_data.filtered_value, out_data.out_row, out_data.out_col);
        end
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_pct);
  end

  // watchdog: any handshake or register write rearms it
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    in_item_t    it;
    out_item_t   px;
    int          grp;
    int          n_req;
    logic [3:0]  rt, ct;
    logic [10:0] w;
    logic [63:0] rlo, rhi, clo, chi;

    rst = 1'b1; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_ROW_LO; cfg_data = '0;
    mismatches = 0; force_frame = 1'b0;
    tx_pct = 38; rx_pct = 61;
    sh_row_coeffs = '0; sh_col_coeffs = '0;
    sh_row_taps = 4'd1; sh_col_taps = 4'd1; sh_width = 11'd1024; sh_add_mode = 1'b0;
    foreach (win_hist[k]) win_hist[k] = '0;
    col_pos = 0; row_pos = 0; slot_pos = 0; rows_wrapped = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    grp = 0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].grp != grp) begin
        grp = dir_tab[i].grp;
        load_group(grp);
      end
      it.sample      = dir_tab[i].smp;
      it.prior_value = dir_tab[i].pri;
      it.frame_start = dir_tab[i].fs;
      px.filtered_value = dir_tab[i].val;
      px.out_row        = 12'(dir_tab[i].row);
      px.out_col        = 10'(dir_tab[i].col);
      send_request(it, dir_tab[i].typed, px);
    end

    // random phases; the last one streams one-pixel lines through a
    // three-line column
    for (int ph = 0; ph < 13; ph++) begin
      if (ph == 4) begin tx_pct = 61; rx_pct = 38; end
      if (ph == 8) begin tx_pct = 0; rx_pct = 0; end
      rt = 4'($urandom_range(1, 8));
      ct = 4'($urandom_range(1, 8));
      w  = 11'($urandom_range(rt, rt + 12));
      n_req = 85;
      if (ph % 4 == 3) begin
        rlo = {4{16'h7fff}}; rhi = {4{16'h8000}};
        clo = {2{16'h8000, 16'h7fff}}; chi = {2{16'h7fff, 16'h8000}};
      end else begin
        rlo = {$urandom, $urandom}; rhi = {$urandom, $urandom};
        clo = {$urandom, $urandom}; chi = {$urandom, $urandom};
      end
      if (ph == 2) begin            // clamped width, one long line
        rt = 4'd8; ct = 4'd1; w = 11'd2047; n_req = 150;
      end
      if (ph == 5) begin            // out-of-range tap counts
        rt = 4'd0; ct = 4'd15; w = 11'($urandom_range(1, 6));
      end
      if (ph == 12) begin           // one-pixel lines
        rt = 4'd1; ct = 4'd3; w = 11'd1; n_req = 40;
      end
      load_setting(rlo, rhi, clo, chi, rt, ct, w, 1'($urandom_range(1)));
      for (int i = 0; i < n_req; i++) begin
        it = rand_request();
        if (ph == 12) it.frame_start = 1'b0;
        send_request(it, 1'b0, px);
      end
    end

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);

    if (mismatches == 0 && pixel_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
